FILE: hdl/lci_pkg.sv
// Shared types and constants of the line and circle intersection unit.
`default_nettype none

package lci_pkg;

   typedef enum logic [1:0] {
      LCI_POINT    = 2'd0,
      LCI_MISS     = 2'd1,
      LCI_VERTICAL = 2'd2
   } status_type;

   localparam int LIMB_BITS = 32;

endpackage

`default_nettype wire

FILE: hdl/lci_if.sv
// Request and response channel interfaces of the line and circle intersection unit.
`default_nettype none

interface lci_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] direction_x;
   logic signed [COORD_BITS-1:0] direction_y;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic        [COORD_BITS-2:0] circle_radius;

   modport source (output valid, point_x, point_y, direction_x, direction_y,
                   center_x, center_y, circle_radius, input ready);
   modport sink (input valid, point_x, point_y, direction_x, direction_y,
                 center_x, center_y, circle_radius, output ready);
endinterface

interface lci_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] hit_x;
   logic signed [COORD_BITS-1:0] hit_y;
   lci_pkg::status_type          status;
   logic                         last;

   modport source (output valid, hit_x, hit_y, status, last, input ready);
   modport sink (input valid, hit_x, hit_y, status, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/line_circle_intersection_unit.sv
// Top level of the line and circle intersection unit: full pipeline and result sequencing.
// Throughput: one request per cycle into the pipeline, unless the result register is held
// by back-pressure or by the first point of a hit; a hit gives two responses on the single
// response port, a miss or vertical line one.
// The square root takes one root bit per stage, the divider one quotient bit per stage.
// Reset clears all valid bits and the response phase; payload registers are not reset.
`default_nettype none

module line_circle_intersection_unit #(
   parameter int COORD_BITS = 32
) (
   input wire logic  clock,
   input wire logic  reset,
   lci_req_if.sink   req_if,
   lci_rsp_if.source rsp_if
);

   localparam int CB  = COORD_BITS;
   localparam int UW  = CB + 1;
   localparam int CW  = 2 * CB + 2;
   localparam int LWS = 2 * CB + 2;
   localparam int DW  = 4 * CB + 5;
   localparam int SW  = 2 * CB - 1;
   localparam int DU  = 2 * SW;
   localparam int RMW = SW + 2;
   localparam int XW  = 3 * CB + 2;
   localparam int MW  = 3 * CB + 1;
   localparam int NW  = 3 * CB + 4;
   localparam int DVW = 3 * CB + 2;
   localparam int QB  = CB + 1;
   localparam logic signed [CB+2:0] BIAS = (CB+3)'(1) << CB;
   localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

   typedef struct packed {
      logic signed [CB-1:0] dx;
      logic signed [CB-1:0] dy;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic                 vert;
   } front_type;

   typedef struct packed {
      logic signed [CB-1:0]  dx;
      logic signed [CB-1:0]  dy;
      logic signed [CB-1:0]  cx;
      logic signed [CB-1:0]  cy;
      logic signed [LWS-1:0] l;
      logic                  vert;
   } mid_type;

   typedef struct packed {
      logic signed [CB-1:0]  dx;
      logic signed [CB-1:0]  dy;
      logic signed [CB-1:0]  cx;
      logic signed [CB-1:0]  cy;
      logic signed [LWS-1:0] l;
      logic signed [XW-1:0]  xc;
      logic signed [XW-1:0]  ycn;
      logic                  vert;
      logic                  miss;
   } sq_type;

   typedef struct packed {
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic [2*CB-1:0]      l;
      lci_pkg::status_type  status;
   } dv_type;

   function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] base,
                                                    input logic [QB-1:0] q);
      logic signed [CB+2:0] sum;
      sum = (CB+3)'(base) + (CB+3)'(signed'({1'b0, q})) - BIAS;
      if (sum > (CB+3)'(MAXC)) begin
         sat_add = MAXC;
      end else if (sum < (CB+3)'(MINC)) begin
         sat_add = MINC;
      end else begin
         sat_add = sum[CB-1:0];
      end
   endfunction

   logic adv;
   logic rsp_last;

   // front stage
   logic              s1_valid_ff;
   front_type         s1_side_in;
   front_type         s1_side_ff;
   logic signed [UW-1:0] s1_ux_ff;
   logic signed [UW-1:0] s1_uy_ff;
   logic signed [CB-1:0] s1_r_ff;

   logic signed [CB+UW-1:0] p_dyux;
   logic signed [CB+UW-1:0] p_dxuy;
   logic signed [2*CB-1:0]  p_dxx;
   logic signed [2*CB-1:0]  p_dyy;
   logic signed [2*CB-1:0]  p_rr;

   logic      m1_valid_ff [2];
   front_type m1_side_ff  [2];

   logic                   cl_valid_ff;
   mid_type                cl_side_ff;
   logic signed [CW-1:0]   c_ff;
   logic signed [2*CB-1:0] rr_ff;

   logic signed [4*CB+1:0] p_rrl;
   logic signed [4*CB+3:0] p_cc;
   logic signed [XW-1:0]   p_xc;
   logic signed [XW-1:0]   p_ycn;

   logic    m2_valid_ff [2];
   mid_type m2_side_ff  [2];

   logic signed [DW-1:0] d_in;

   logic           sq_valid_ff [0:SW];
   sq_type         sq_side_ff  [0:SW];
   logic [DU-1:0]  sq_rad_ff   [0:SW];
   logic [RMW-1:0] sq_rem_ff   [0:SW];
   logic [SW-1:0]  sq_root_ff  [0:SW];

   logic signed [CB:0]   m3_a;
   logic signed [CB:0]   m3_e;
   logic signed [SW:0]   m3_s;
   logic signed [MW-1:0] p_as;
   logic signed [MW-1:0] p_es;
   logic                 m3_valid_ff [2];
   sq_type               m3_side_ff  [2];

   logic signed [NW-1:0] n_bias;
   logic signed [NW-1:0] n_xc;
   logic signed [NW-1:0] n_yc;
   logic signed [NW-1:0] n_as;
   logic signed [NW-1:0] n_es;
   dv_type               dv_side_in;

   logic           dv_valid_ff [0:QB];
   dv_type         dv_side_ff  [0:QB];
   logic [DVW-1:0] dv_rem_ff   [0:QB][4];
   logic [QB-1:0]  dv_q_ff     [0:QB][4];

   logic                 fin_valid_ff;
   lci_pkg::status_type  fin_status_ff;
   logic signed [CB-1:0] fin_x_ff [2];
   logic signed [CB-1:0] fin_y_ff [2];
   logic                 phase_ff;
   logic                 phase_in;

   assign rsp_last     = (fin_status_ff != lci_pkg::LCI_POINT) || phase_ff;
   assign adv          = !fin_valid_ff || (rsp_if.ready && rsp_last);
   assign req_if.ready = adv;

   assign s1_side_in.dx   = req_if.direction_x;
   assign s1_side_in.dy   = req_if.direction_y;
   assign s1_side_in.cx   = req_if.center_x;
   assign s1_side_in.cy   = req_if.center_y;
   assign s1_side_in.vert = (req_if.direction_x == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_if.valid;
      end
      if (adv) begin
         s1_side_ff <= s1_side_in;
         s1_ux_ff   <= UW'(req_if.point_x) - UW'(req_if.center_x);
         s1_uy_ff   <= UW'(req_if.point_y) - UW'(req_if.center_y);
         s1_r_ff    <= signed'({1'b0, req_if.circle_radius});
      end
   end

   lci_mul #(.A_BITS(CB), .B_BITS(UW)) u_mul_dyux (
      .clock(clock), .enable(adv), .op_a(s1_side_ff.dy), .op_b(s1_ux_ff), .product(p_dyux));
   lci_mul #(.A_BITS(CB), .B_BITS(UW)) u_mul_dxuy (
      .clock(clock), .enable(adv), .op_a(s1_side_ff.dx), .op_b(s1_uy_ff), .product(p_dxuy));
   lci_mul #(.A_BITS(CB), .B_BITS(CB)) u_mul_dxx (
      .clock(clock), .enable(adv), .op_a(s1_side_ff.dx), .op_b(s1_side_ff.dx), .product(p_dxx));
   lci_mul #(.A_BITS(CB), .B_BITS(CB)) u_mul_dyy (
      .clock(clock), .enable(adv), .op_a(s1_side_ff.dy), .op_b(s1_side_ff.dy), .product(p_dyy));
   lci_mul #(.A_BITS(CB), .B_BITS(CB)) u_mul_rr (
      .clock(clock), .enable(adv), .op_a(s1_r_ff), .op_b(s1_r_ff), .product(p_rr));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff[0] <= 1'b0;
         m1_valid_ff[1] <= 1'b0;
         cl_valid_ff    <= 1'b0;
      end else if (adv) begin
         m1_valid_ff[0] <= s1_valid_ff;
         m1_valid_ff[1] <= m1_valid_ff[0];
         cl_valid_ff    <= m1_valid_ff[1];
      end
      if (adv) begin
         m1_side_ff[0]   <= s1_side_ff;
         m1_side_ff[1]   <= m1_side_ff[0];
         cl_side_ff.dx   <= m1_side_ff[1].dx;
         cl_side_ff.dy   <= m1_side_ff[1].dy;
         cl_side_ff.cx   <= m1_side_ff[1].cx;
         cl_side_ff.cy   <= m1_side_ff[1].cy;
         cl_side_ff.vert <= m1_side_ff[1].vert;
         cl_side_ff.l    <= LWS'(p_dxx) + LWS'(p_dyy);
         c_ff            <= CW'(p_dyux) - CW'(p_dxuy);
         rr_ff           <= p_rr;
      end
   end

   lci_mul #(.A_BITS(2*CB), .B_BITS(LWS)) u_mul_rrl (
      .clock(clock), .enable(adv), .op_a(rr_ff), .op_b(cl_side_ff.l), .product(p_rrl));
   lci_mul #(.A_BITS(CW), .B_BITS(CW)) u_mul_cc (
      .clock(clock), .enable(adv), .op_a(c_ff), .op_b(c_ff), .product(p_cc));
   lci_mul #(.A_BITS(CB), .B_BITS(CW)) u_mul_xc (
      .clock(clock), .enable(adv), .op_a(cl_side_ff.dy), .op_b(c_ff), .product(p_xc));
   lci_mul #(.A_BITS(CB), .B_BITS(CW)) u_mul_ycn (
      .clock(clock), .enable(adv), .op_a(cl_side_ff.dx), .op_b(c_ff), .product(p_ycn));

   assign d_in = DW'(p_rrl) - DW'(p_cc);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff[0] <= 1'b0;
         m2_valid_ff[1] <= 1'b0;
         sq_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         m2_valid_ff[0] <= cl_valid_ff;
         m2_valid_ff[1] <= m2_valid_ff[0];
         sq_valid_ff[0] <= m2_valid_ff[1];
      end
      if (adv) begin
         m2_side_ff[0]      <= cl_side_ff;
         m2_side_ff[1]      <= m2_side_ff[0];
         sq_side_ff[0].dx   <= m2_side_ff[1].dx;
         sq_side_ff[0].dy   <= m2_side_ff[1].dy;
         sq_side_ff[0].cx   <= m2_side_ff[1].cx;
         sq_side_ff[0].cy   <= m2_side_ff[1].cy;
         sq_side_ff[0].l    <= m2_side_ff[1].l;
         sq_side_ff[0].vert <= m2_side_ff[1].vert;
         sq_side_ff[0].xc   <= p_xc;
         sq_side_ff[0].ycn  <= p_ycn;
         sq_side_ff[0].miss <= d_in[DW-1];
         sq_rad_ff[0]       <= d_in[DU-1:0];
         sq_rem_ff[0]       <= '0;
         sq_root_ff[0]      <= '0;
      end
   end

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      logic           take;

      assign rem_sh = {sq_rem_ff[k][RMW-3:0], sq_rad_ff[k][DU-1 -: 2]};
      assign trial  = {sq_root_ff[k], 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         if (adv) begin
            sq_side_ff[k+1] <= sq_side_ff[k];
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][DU-3:0], 2'b00};
            sq_rem_ff[k+1]  <= take ? rem_sh - trial : rem_sh;
            sq_root_ff[k+1] <= {sq_root_ff[k][SW-2:0], take};
         end
      end
   end

   assign m3_a = sq_side_ff[SW].dx[CB-1] ? -(CB+1)'(sq_side_ff[SW].dx)
                                          : (CB+1)'(sq_side_ff[SW].dx);
   assign m3_e = sq_side_ff[SW].dx[CB-1] ? -(CB+1)'(sq_side_ff[SW].dy)
                                          : (CB+1)'(sq_side_ff[SW].dy);
   assign m3_s = signed'({1'b0, sq_root_ff[SW]});

   lci_mul #(.A_BITS(CB+1), .B_BITS(SW+1)) u_mul_as (
      .clock(clock), .enable(adv), .op_a(m3_a), .op_b(m3_s), .product(p_as));
   lci_mul #(.A_BITS(CB+1), .B_BITS(SW+1)) u_mul_es (
      .clock(clock), .enable(adv), .op_a(m3_e), .op_b(m3_s), .product(p_es));

   // bias each numerator by L << CB so the floor division runs on nonnegative values
   assign n_bias = NW'(m3_side_ff[1].l) <<< CB;
   assign n_xc   = NW'(m3_side_ff[1].xc);
   assign n_yc   = -NW'(m3_side_ff[1].ycn);
   assign n_as   = NW'(p_as);
   assign n_es   = NW'(p_es);

   assign dv_side_in.cx = m3_side_ff[1].cx;
   assign dv_side_in.cy = m3_side_ff[1].cy;
   assign dv_side_in.l  = m3_side_ff[1].l[2*CB-1:0];
   assign dv_side_in.status = m3_side_ff[1].vert ? lci_pkg::LCI_VERTICAL :
                              m3_side_ff[1].miss ? lci_pkg::LCI_MISS : lci_pkg::LCI_POINT;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff[0] <= 1'b0;
         m3_valid_ff[1] <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         m3_valid_ff[0] <= sq_valid_ff[SW];
         m3_valid_ff[1] <= m3_valid_ff[0];
         dv_valid_ff[0] <= m3_valid_ff[1];
      end
      if (adv) begin
         m3_side_ff[0]   <= sq_side_ff[SW];
         m3_side_ff[1]   <= m3_side_ff[0];
         dv_side_ff[0]   <= dv_side_in;
         dv_rem_ff[0][0] <= DVW'(n_xc - n_as + n_bias);
         dv_rem_ff[0][1] <= DVW'(n_yc - n_es + n_bias);
         dv_rem_ff[0][2] <= DVW'(n_xc + n_as + n_bias);
         dv_rem_ff[0][3] <= DVW'(n_yc + n_es + n_bias);
         for (int j = 0; j < 4; j++) begin
            dv_q_ff[0][j] <= '0;
         end
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic [DVW-1:0] dsh;

      assign dsh = DVW'(dv_side_ff[k].l) << (QB - 1 - k);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
         if (adv) begin
            dv_side_ff[k+1] <= dv_side_ff[k];
            for (int j = 0; j < 4; j++) begin
               dv_rem_ff[k+1][j] <= (dv_rem_ff[k][j] >= dsh) ? dv_rem_ff[k][j] - dsh
                                                             : dv_rem_ff[k][j];
               dv_q_ff[k+1][j]   <= {dv_q_ff[k][j][QB-2:0], (dv_rem_ff[k][j] >= dsh)};
            end
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (rsp_if.valid && rsp_if.ready) begin
         phase_in = !rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (adv) begin
            fin_valid_ff <= dv_valid_ff[QB];
         end
      end
      if (adv) begin
         fin_status_ff <= dv_side_ff[QB].status;
         for (int j = 0; j < 2; j++) begin
            if (dv_side_ff[QB].status == lci_pkg::LCI_POINT) begin
               fin_x_ff[j] <= sat_add(dv_side_ff[QB].cx, dv_q_ff[QB][2*j]);
               fin_y_ff[j] <= sat_add(dv_side_ff[QB].cy, dv_q_ff[QB][2*j+1]);
            end else begin
               fin_x_ff[j] <= '0;
               fin_y_ff[j] <= '0;
            end
         end
      end
   end

   assign rsp_if.valid  = fin_valid_ff;
   assign rsp_if.hit_x  = phase_ff ? fin_x_ff[1] : fin_x_ff[0];
   assign rsp_if.hit_y  = phase_ff ? fin_y_ff[1] : fin_y_ff[0];
   assign rsp_if.status = fin_status_ff;
   assign rsp_if.last   = rsp_last;

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_last) |=> (rsp_if.valid && phase_ff))
      else $error("second point of a hit did not follow the first");

   a_phase_only_hits: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (fin_valid_ff && fin_status_ff == lci_pkg::LCI_POINT))
      else $error("second phase without a pending hit");

   a_last_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_last) |=> !phase_ff)
      else $error("phase not cleared after final response");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !adv) |=> (fin_valid_ff && $stable(fin_x_ff[1]) && $stable(fin_status_ff)))
      else $error("result register changed while stalled");

endmodule

`default_nettype wire

FILE: hdl/lci_mul.sv
// Two-stage signed multiplier built from registered 32x32 partial products.
`default_nettype none

module lci_mul #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            enable,
   input  wire logic signed [A_BITS-1:0]        op_a,
   input  wire logic signed [B_BITS-1:0]        op_b,
   output logic signed [A_BITS+B_BITS-1:0]      product
);

   localparam int LIMB   = lci_pkg::LIMB_BITS;
   localparam int P_BITS = A_BITS + B_BITS;
   localparam int N      = (P_BITS + LIMB - 1) / LIMB;
   localparam int X_BITS = N * LIMB;

   logic [X_BITS-1:0] a_ext;
   logic [X_BITS-1:0] b_ext;
   logic [2*LIMB-1:0] pp_ff [N][N];
   logic [X_BITS-1:0] acc_in;
   logic [X_BITS-1:0] acc_ff;

   assign a_ext = X_BITS'(op_a);
   assign b_ext = X_BITS'(op_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
               pp_ff[i][j] <= (i + j < N) ?
                  (2*LIMB)'(a_ext[i*LIMB +: LIMB]) * (2*LIMB)'(b_ext[j*LIMB +: LIMB]) : '0;
            end
         end
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            if (i + j < N) begin
               acc_in = acc_in + (X_BITS'(pp_ff[i][j]) << (LIMB * (i + j)));
            end
         end
      end
   end

   assign product = signed'(acc_ff[P_BITS-1:0]);

endmodule

`default_nettype wire

FILE: bench/line_circle_intersection_unit_tb.sv
// Testbench of the line and circle intersection unit: directed table, random queries, checker.
`default_nettype none

module line_circle_intersection_unit_tb;

   localparam int COORDS    = 32;
   localparam int NUM_ITEMS = 1600;
   localparam int CYCLE_CAP = 600000;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [COORDS-1:0] px, py, dx, dy, cx, cy;
      logic [COORDS-2:0]        radius;
   } query_type;

   typedef struct {
      logic signed [COORDS-1:0] hit_x, hit_y;
      lci_pkg::status_type      status;
      logic                     last;
   } hit_type;

   typedef struct {
      query_type           q;
      bit                  typed;
      lci_pkg::status_type want;
   } row_type;

   logic clock;
   logic reset;
   bit   calm;

   lci_req_if #(.COORD_BITS(COORDS)) req_if ();
   lci_rsp_if #(.COORD_BITS(COORDS)) rsp_if ();

   line_circle_intersection_unit #(.COORD_BITS(COORDS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   hit_type pending_hits[$];
   int      mismatches;
   int      cycles;
   int      n_points, n_misses, n_verticals, n_queries;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic wide_type widen(logic signed [COORDS-1:0] v);
      return v;
   endfunction

   function automatic wide_type floor_div(wide_type num, wide_type den);
      wide_type quo;
      quo = num / den;
      if (num < 0 && (num % den) != 0) quo = quo - 1;
      return quo;
   endfunction

   function automatic logic [255:0] int_sqrt(logic [255:0] val);
      logic [255:0] root;
      logic [255:0] trial;
      root = '0;
      for (int b = 127; b >= 0; b--) begin
         trial = root | (256'd1 << b);
         if (trial * trial <= val) root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [COORDS-1:0] clamp_coord(logic signed [COORDS-1:0] base,
                                                             wide_type off);
      wide_type v;
      wide_type hi;
      v  = widen(base) + off;
      hi = (wide_type'(1) <<< (COORDS - 1)) - 1;
      if (v > hi) return hi[COORDS-1:0];
      if (v < -hi - 1) return {1'b1, {(COORDS-1){1'b0}}};
      return v[COORDS-1:0];
   endfunction

   function automatic hit_type flag_hit(lci_pkg::status_type st);
      hit_type h;
      h.hit_x  = '0;
      h.hit_y  = '0;
      h.status = st;
      h.last   = 1'b1;
      return h;
   endfunction

   task automatic predict_hits(query_type q);
      wide_type dxw, dyw, c, len, disc, xc, yc, abs_s, e_s;
      logic [255:0] root;
      hit_type h;
      if (q.dx == 0) begin
         pending_hits.push_back(flag_hit(lci_pkg::LCI_VERTICAL));
         return;
      end
      dxw  = widen(q.dx);
      dyw  = widen(q.dy);
      c    = dyw * (widen(q.px) - widen(q.cx)) - dxw * (widen(q.py) - widen(q.cy));
      len  = dxw * dxw + dyw * dyw;
      disc = wide_type'({225'd0, q.radius}) * wide_type'({225'd0, q.radius}) * len - c * c;
      if (disc < 0) begin
         pending_hits.push_back(flag_hit(lci_pkg::LCI_MISS));
         return;
      end
      root  = int_sqrt(disc);
      xc    = dyw * c;
      yc    = -(dxw * c);
      abs_s = (dxw < 0 ? -dxw : dxw) * $signed(root);
      e_s   = (dxw < 0 ? -dyw : dyw) * $signed(root);
      h.status = lci_pkg::LCI_POINT;
      h.hit_x  = clamp_coord(q.cx, floor_div(xc - abs_s, len));
      h.hit_y  = clamp_coord(q.cy, floor_div(yc - e_s, len));
      h.last   = 1'b0;
      pending_hits.push_back(h);
      h.hit_x  = clamp_coord(q.cx, floor_div(xc + abs_s, len));
      h.hit_y  = clamp_coord(q.cy, floor_div(yc + e_s, len));
      h.last   = 1'b1;
      pending_hits.push_back(h);
   endtask

   function automatic query_type make_query(int mode);
      query_type q;
      int        scale;
      q.px = $urandom; q.py = $urandom; q.dx = $urandom; q.dy = $urandom;
      q.cx = $urandom; q.cy = $urandom; q.radius = $urandom;
      case (mode)
         0: ;
         1: q.dx = '0;
         2: begin
            q.dy = $urandom_range(0, 3) == 0 ? '0 : q.dy;
            q.px = q.cx + 32'(signed'(q.radius[22:0]) >>> 2) - 32'(q.radius[22:0] >>> 3);
            q.py = q.cy;
            q.radius = {8'd0, q.radius[22:0]};
         end
         default: begin
            scale = $urandom_range(4, 30);
            q.cx = $signed(q.cx) >>> (31 - scale);
            q.cy = $signed(q.cy) >>> (31 - scale);
            q.radius = q.radius >> (30 - $urandom_range(2, scale));
            q.px = q.cx + ($signed(32'($urandom)) >>> (32 - $clog2(q.radius + 2)));
            q.py = q.cy + ($signed(32'($urandom)) >>> (32 - $clog2(q.radius + 2)));
            q.dx = $signed(q.dx) >>> $urandom_range(0, 30);
            q.dy = $signed(q.dy) >>> $urandom_range(0, 30);
            if (q.dx == 0) q.dx = 32'sd1;
         end
      endcase
      return q;
   endfunction

   task automatic send_query(query_type q, bit typed, lci_pkg::status_type want);
      if (!calm) begin
         while ($urandom_range(0, 99) < 25) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid         = 1'b1;
      req_if.point_x       = q.px;
      req_if.point_y       = q.py;
      req_if.direction_x   = q.dx;
      req_if.direction_y   = q.dy;
      req_if.center_x      = q.cx;
      req_if.center_y      = q.cy;
      req_if.circle_radius = q.radius;
      do @(posedge clock); while (!req_if.ready);
      if (typed) pending_hits.push_back(flag_hit(want));
      else predict_hits(q);
      n_queries++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 25);
   end

   always @(posedge clock) begin
      hit_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: x=%0d y=%0d status=%s last=%0b",
                        rsp_if.hit_x, rsp_if.hit_y, rsp_if.status.name(), rsp_if.last);
         end else begin
            want = pending_hits.pop_front();
            case (want.status)
               lci_pkg::LCI_POINT:    n_points++;
               lci_pkg::LCI_MISS:     n_misses++;
               lci_pkg::LCI_VERTICAL: n_verticals++;
               default: ;
            endcase
            if (rsp_if.hit_x !== want.hit_x || rsp_if.hit_y !== want.hit_y ||
                rsp_if.status !== want.status || rsp_if.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%0d y=%0d %s last=%0b, got x=%0d y=%0d %s last=%0b",
                           want.hit_x, want.hit_y, want.status.name(), want.last,
                           rsp_if.hit_x, rsp_if.hit_y, rsp_if.status.name(), rsp_if.last);
            end
         end
      end
   end

   initial begin
      row_type   rows[$];
      row_type   r;
      query_type q;
      int        waited;
      localparam logic signed [31:0] ONE  = 32'sh0001_0000;
      localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
      localparam logic signed [31:0] SMIN = 32'sh8000_0000;
      localparam logic [30:0]        RMAX = 31'h7fff_ffff;

      reset  = 1'b1;
      calm   = 1'b0;
      cycles = 0;
      req_if.valid = 1'b0;
      req_if.point_x = '0; req_if.point_y = '0;
      req_if.direction_x = '0; req_if.direction_y = '0;
      req_if.center_x = '0; req_if.center_y = '0; req_if.circle_radius = '0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // px py dx dy cx cy radius, typed, expected status
      rows.push_back('{'{0, 0, 0, ONE, 0, 0, ONE}, 1, lci_pkg::LCI_VERTICAL});
      rows.push_back('{'{SMAX, SMIN, 0, 0, SMIN, SMAX, RMAX}, 1, lci_pkg::LCI_VERTICAL});
      rows.push_back('{'{0, 4 * ONE, ONE, 0, 0, 0, ONE}, 1, lci_pkg::LCI_MISS});
      rows.push_back('{'{0, 0, ONE, 0, 0, 0, 0}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, ONE, ONE, 0, 0, 0, ONE}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, 0, ONE, 0, 0, 0, 2 * ONE}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, 0, -ONE, ONE, ONE, -ONE, 3 * ONE}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, 0, ONE, ONE, 0, 0, ONE}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, 0, 1, SMAX, 0, 0, RMAX}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, RMAX}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, RMAX}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{SMAX, SMIN, SMIN, SMAX, SMIN, SMAX, RMAX}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{SMIN, SMAX, SMAX, SMIN, SMAX, SMIN, 0}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{0, 0, SMIN, 1, SMAX, SMIN, RMAX}, 0, lci_pkg::LCI_POINT});
      rows.push_back('{'{-1, -1, -1, -1, 0, 0, 1}, 0, lci_pkg::LCI_POINT});

      foreach (rows[i]) send_query(rows[i].q, rows[i].typed, rows[i].want);

      for (int i = 0; i < NUM_ITEMS; i++) begin
         calm = (i >= 500 && i < 700);
         if (i == 1000) begin
            req_if.valid = 1'b0;
            while (pending_hits.size() != 0) @(negedge clock);
         end
         q = make_query($urandom_range(0, 9));
         send_query(q, 1'b0, lci_pkg::LCI_POINT);
      end
      req_if.valid = 1'b0;
      calm = 1'b0;

      waited = 0;
      while (pending_hits.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (150) @(posedge clock);

      $display("%0d queries sent: %0d points, %0d misses, %0d vertical lines checked",
               n_queries, n_points, n_misses, n_verticals);
      $display("directed rows cover tangents, extremes and both error cases");
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
